FILE: design/signed_sum_way_counter_assert.svh
// Assertion macros for the signed-sum way counter.
// Used by the top level; needs clk and rst_n in scope at each use.
`ifndef SIGNED_SUM_WAY_COUNTER_ASSERT_SVH
`define SIGNED_SUM_WAY_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS
`define SSW_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssw assertion failed");
`define SSW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssw assertion failed");
`else
`define SSW_ASSERT_IMPL(lbl, ante, cons)
`define SSW_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: design/ssw_pkg.sv
// Shared widths and defaults for the signed-sum way counter.
// No dependencies; imported by the table RAM and the top level.
package ssw_pkg;

    localparam int VALUE_W       = 10;
    localparam int TARGET_W      = 12;
    localparam int COUNT_W       = 33;
    localparam int TOTAL_W       = 16;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 40;
    localparam int DEF_MAX_SUM   = 1024;
    localparam int DEF_MAX_ITEMS = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef logic [COUNT_W-1:0] count_t;

endpackage

FILE: design/ssw_ram.sv
// Way-count table RAM: one write port, two registered read ports.
// Depends on ssw_pkg for the default entry width.
module ssw_ram
    import ssw_pkg::*;
#(
    parameter int DEPTH  = 2 * DEF_MAX_SUM + 1,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = COUNT_W
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: design/signed_sum_way_counter.sv
// Signed-sum way counter top level: sequencer, fold datapath, ping-pong table.
// Depends on ssw_pkg, ssw_ram and signed_sum_way_counter_assert.svh.
// An accepted word that is folded passes an accept step in ST_IDLE, a fold of
// one table entry per cycle through the two-read-port RAM, and a drain step.
// A word that sets the range error is not folded. On a last word the result passes
// ST_RRD and ST_RWAIT after the fold. rst_n clears control state and the target to
// zero; the table needs no clearing pass, the first fold of a set reads it as initial.
`include "signed_sum_way_counter_assert.svh"

module signed_sum_way_counter
    import ssw_pkg::*;
#(
    parameter int MAX_SUM   = DEF_MAX_SUM,
    parameter int MAX_ITEMS = DEF_MAX_ITEMS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TARGET_W-1:0]  cfg_data,   // target_sum
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [9:0] value, rest zero
    input  logic                 s_tlast,    // is_last
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // [32:0] way_count, rest zero
    output logic                 m_tuser     // out_of_range
);

    localparam int SPAN   = 2 * MAX_SUM + 1;
    localparam int IDX_W  = $clog2(SPAN);
    localparam int AW     = (IDX_W > VALUE_W ? IDX_W : VALUE_W) + 1;
    localparam int TW     = (TARGET_W > IDX_W + 1 ? TARGET_W : IDX_W + 1) + 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 2);
    localparam int TSUM_W = TOTAL_W + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FOLD  = 3'd1;
    localparam logic [2:0] ST_FEND  = 3'd2;
    localparam logic [2:0] ST_RRD   = 3'd3;
    localparam logic [2:0] ST_RWAIT = 3'd4;

    logic [2:0]                 state_reg, state_next;
    logic signed [TARGET_W-1:0] target_reg;
    logic [VALUE_W-1:0]         v_reg, v_next;
    logic                       last_reg, last_next;
    logic [IDX_W-1:0]           rd_idx_reg, rd_idx_next;
    logic [TOTAL_W-1:0]         mag_reg, mag_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       err_reg, err_next;
    logic                       init_reg, init_next;
    logic                       src_sel_reg, src_sel_next;
    logic                       m_valid_reg, m_valid_next;
    count_t                     m_count_reg;
    logic                       m_oor_reg;

    logic                       p_valid_reg;
    logic [IDX_W-1:0]           p_idx_reg;
    logic                       p_lo_ok_reg, p_hi_ok_reg;
    logic                       p_lo_ctr_reg, p_hi_ctr_reg;

    logic [AW-1:0]              i_ext, v_ext, lo_pos, hi_pos;
    logic                       lo_ok, hi_ok, lo_ctr, hi_ctr;
    logic signed [TW-1:0]       tgt_off;
    logic                       tgt_in;
    logic [IDX_W-1:0]           tgt_idx;
    logic [IDX_W-1:0]           raddr_a, raddr_b;
    count_t                     r0_a, r0_b, r1_a, r1_b;
    count_t                     src_a, src_b, term_a, term_b, wdata;
    logic [COUNT_W:0]           sum_w;
    logic [TSUM_W-1:0]          total;
    logic                       bad;
    logic                       accept, out_free;
    count_t                     res_count;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign i_ext  = AW'(rd_idx_reg);
    assign v_ext  = AW'(v_reg);
    assign lo_pos = i_ext - v_ext;
    assign hi_pos = i_ext + v_ext;
    assign lo_ok  = (i_ext >= v_ext);
    assign hi_ok  = (hi_pos < AW'(SPAN));
    assign lo_ctr = lo_ok && (lo_pos == AW'(MAX_SUM));
    assign hi_ctr = hi_ok && (hi_pos == AW'(MAX_SUM));

    assign tgt_off = TW'(target_reg) + TW'(MAX_SUM);
    assign tgt_in  = (tgt_off >= 0) && (tgt_off < TW'(SPAN));
    assign tgt_idx = tgt_off[IDX_W-1:0];

    assign raddr_a = (state_reg == ST_FOLD) ? lo_pos[IDX_W-1:0] : tgt_idx;
    assign raddr_b = hi_pos[IDX_W-1:0];

    ssw_ram #(
        .DEPTH  (SPAN),
        .ADDR_W (IDX_W),
        .DATA_W (COUNT_W)
    ) u_ram0 (
        .clk     (clk),
        .we      (p_valid_reg && src_sel_reg),
        .waddr   (p_idx_reg),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (r0_a),
        .rdata_b (r0_b)
    );

    ssw_ram #(
        .DEPTH  (SPAN),
        .ADDR_W (IDX_W),
        .DATA_W (COUNT_W)
    ) u_ram1 (
        .clk     (clk),
        .we      (p_valid_reg && !src_sel_reg),
        .waddr   (p_idx_reg),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (r1_a),
        .rdata_b (r1_b)
    );

    assign src_a  = src_sel_reg ? r1_a : r0_a;
    assign src_b  = src_sel_reg ? r1_b : r0_b;
    assign term_a = init_reg ? COUNT_W'(p_lo_ctr_reg) : (p_lo_ok_reg ? src_a : '0);
    assign term_b = init_reg ? COUNT_W'(p_hi_ctr_reg) : (p_hi_ok_reg ? src_b : '0);
    assign sum_w  = {1'b0, term_a} + {1'b0, term_b};
    assign wdata  = sum_w[COUNT_W] ? COUNT_MAX : sum_w[COUNT_W-1:0];

    assign total = {1'b0, mag_reg} + TSUM_W'(v_next);
    assign bad   = (cnt_reg >= CNT_W'(MAX_ITEMS)) || (total > TSUM_W'(MAX_SUM));

    always_comb
    begin
        if (err_reg || !tgt_in)
        begin
            res_count = '0;
        end
        else if (init_reg)
        begin
            res_count = COUNT_W'(tgt_off == TW'(MAX_SUM));
        end
        else
        begin
            res_count = src_a;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        v_next       = v_reg;
        last_next    = last_reg;
        rd_idx_next  = rd_idx_reg;
        mag_next     = mag_reg;
        cnt_next     = cnt_reg;
        err_next     = err_reg;
        init_next    = init_reg;
        src_sel_next = src_sel_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (accept)
        begin
            v_next    = s_tdata[VALUE_W-1:0];
            last_next = s_tlast;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!err_reg)
                    begin
                        err_next = bad;
                        mag_next = total[TOTAL_W] ? TOTAL_MAX : total[TOTAL_W-1:0];
                        if (cnt_reg < CNT_W'(MAX_ITEMS + 1))
                        begin
                            cnt_next = CNT_W'(cnt_reg + 1'b1);
                        end
                    end
                    if (!err_reg && !bad)
                    begin
                        state_next  = ST_FOLD;
                        rd_idx_next = '0;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_RRD;
                    end
                end
            end
            ST_FOLD:
            begin
                if (rd_idx_reg == IDX_W'(SPAN - 1))
                begin
                    state_next = ST_FEND;
                end
                else
                begin
                    rd_idx_next = IDX_W'(rd_idx_reg + 1'b1);
                end
            end
            ST_FEND:
            begin
                src_sel_next = !src_sel_reg;
                init_next    = 1'b0;
                state_next   = last_reg ? ST_RRD : ST_IDLE;
            end
            ST_RRD:
            begin
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    mag_next     = '0;
                    cnt_next     = '0;
                    err_next     = 1'b0;
                    init_next    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            target_reg  <= '0;
            last_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            mag_reg     <= '0;
            cnt_reg     <= '0;
            err_reg     <= 1'b0;
            init_reg    <= 1'b1;
            src_sel_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            last_reg    <= last_next;
            rd_idx_reg  <= rd_idx_next;
            mag_reg     <= mag_next;
            cnt_reg     <= cnt_next;
            err_reg     <= err_next;
            init_reg    <= init_next;
            src_sel_reg <= src_sel_next;
            m_valid_reg <= m_valid_next;
            p_valid_reg <= (state_reg == ST_FOLD);
            if (cfg_valid && cfg_ready)
            begin
                target_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        p_idx_reg    <= rd_idx_reg;
        p_lo_ok_reg  <= lo_ok;
        p_hi_ok_reg  <= hi_ok;
        p_lo_ctr_reg <= lo_ctr;
        p_hi_ctr_reg <= hi_ctr;
        if (state_reg == ST_RWAIT && out_free)
        begin
            m_count_reg <= res_count;
            m_oor_reg   <= err_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_count_reg);
    assign m_tuser  = m_oor_reg;

    `SSW_ASSERT_IMPL(a_oor_zero, m_tvalid && m_tuser, m_tdata == '0)
    `SSW_ASSERT_IMPL(a_no_fold_on_err, state_reg == ST_FOLD, !err_reg)
    `SSW_ASSERT_IMPL(a_fold_in_span, state_reg == ST_FOLD, mag_reg <= TOTAL_W'(MAX_SUM))
    `SSW_ASSERT_NEXT(a_fold_drain, state_reg == ST_FOLD && rd_idx_reg == IDX_W'(SPAN - 1),
        state_reg == ST_FEND && p_valid_reg)

endmodule
